[hw/rtl/cache_tag_lookup_replace_core_defines.svh]
// Assertion macros shared by the cache tag store RTL.
`ifndef CACHE_TAG_LOOKUP_REPLACE_CORE_DEFINES_SVH
`define CACHE_TAG_LOOKUP_REPLACE_CORE_DEFINES_SVH

// Same-cycle implication, checked on clk, off during reset.
`define CTLR_ASSERT_IMP(label, trig, cond) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (trig) |-> (cond)) \
		else $error("cache tag store: implication check failed");

// Next-cycle implication, checked on clk, off during reset.
`define CTLR_ASSERT_NEXT(label, trig, cond) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (cond)) \
		else $error("cache tag store: next-cycle check failed");

`endif

[hw/rtl/ctlr_pkg.sv]
// Types, constants and register codes of the cache tag store.
package ctlr_pkg;

	localparam int NUM_SETS_DEF = 64;
	localparam int NUM_WAYS_DEF = 4;
	localparam int AGE_BITS_DEF = 8;

	localparam int ADDR_W      = 32;
	localparam int TAG_W       = 32;
	localparam int WAY_OUT_W   = 2;
	localparam int CNT_W       = 32;
	localparam int OFFSET_W    = 4;
	localparam int INDEX_W     = 3;
	localparam int WAYS_W      = 3;
	localparam int IDX_FIELD_W = 7;
	localparam int SHAMT_W     = 5;

	localparam int PADDR_W   = 4;
	localparam int PDATA_W   = 32;
	localparam int REG_IDX_W = 2;

	localparam logic [REG_IDX_W-1:0] REG_BLK_OFS_W      = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_SET_SEL_W      = 2'd1;
	localparam logic [REG_IDX_W-1:0] REG_WAYS_IN_USE    = 2'd2;
	localparam logic [REG_IDX_W-1:0] REG_REPLACE_POLICY = 2'd3;

	localparam logic [OFFSET_W-1:0] BLK_OFS_W_RST      = 4'd2;
	localparam logic [INDEX_W-1:0]  SET_SEL_W_RST      = 3'd6;
	localparam logic [WAYS_W-1:0]   WAYS_IN_USE_RST    = 3'd4;
	localparam logic                REPLACE_POLICY_RST = 1'b0;

	localparam logic MODE_LOOKUP     = 1'b0;
	localparam logic MODE_INVALIDATE = 1'b1;

	localparam logic POLICY_LRU  = 1'b0;
	localparam logic POLICY_FIFO = 1'b1;

	typedef struct packed {
		logic              mode;
		logic [ADDR_W-1:0] address;
	} req_t;

	typedef struct packed {
		logic                 hit;
		logic [WAY_OUT_W-1:0] way;
		logic                 evicted;
		logic [CNT_W-1:0]     hit_total;
		logic [CNT_W-1:0]     miss_total;
		logic [CNT_W-1:0]     invalidate_total;
	} rsp_t;

endpackage

[hw/rtl/ctlr_stream_if.sv]
// Valid/ready stream channel carrying one payload word.
interface ctlr_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

[hw/rtl/cache_tag_lookup_replace_core.sv]
// Set-associative cache tag store with LRU or FIFO replacement, top level.
//
// Channels: req (sink) carries one word {mode, address}; mode 0 is a lookup
// that fills on a miss, mode 1 invalidates the matching line. rsp (source)
// returns exactly one word per request: hit, way, evicted and the three
// saturating totals. Both use valid/ready; a word moves when both are high.
// The APB port sets the block offset width, set index width, ways in use and
// replace policy at byte addresses 0, 4, 8 and 12; write it only while idle.
//
// Timing: the set row is read at the accept edge, then one shared tag and
// age comparator steps through the ways in use, one way per cycle, and a
// write state writes the row back and loads the response register. rsp.valid
// and req.ready rise at the same edge, when the write state loads the
// response; a new request is only taken once the previous one is written back.
//
// Stall: a waiting response does not block the next accept; only the write
// cycle of the following request holds until rsp is free.
// Reset: clears all line valid bits, the totals and the registers (offset 2,
// index 6, four ways, LRU). Tags and ages need no clearing: they are only
// used for valid lines, and a line turns valid only by a fill that sets them.
`include "cache_tag_lookup_replace_core_defines.svh"

module cache_tag_lookup_replace_core #(
	parameter int NUM_SETS = ctlr_pkg::NUM_SETS_DEF,
	parameter int NUM_WAYS = ctlr_pkg::NUM_WAYS_DEF,
	parameter int AGE_BITS = ctlr_pkg::AGE_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	ctlr_stream_if.sink                    req,
	ctlr_stream_if.source                  rsp,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [ctlr_pkg::PADDR_W-1:0]   paddr,
	input  logic [ctlr_pkg::PDATA_W-1:0]   pwdata,
	output logic [ctlr_pkg::PDATA_W-1:0]   prdata,
	output logic                           pready
);

	localparam int SET_W     = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
	localparam int WAY_W     = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1;
	localparam int NW_W      = $clog2(NUM_WAYS + 1);
	localparam int CMP_W     = (NW_W > ctlr_pkg::WAYS_W) ? NW_W : ctlr_pkg::WAYS_W;
	localparam int IDX_RANGE = 1 << ctlr_pkg::IDX_FIELD_W;
	localparam int TAG_W     = ctlr_pkg::TAG_W;
	localparam int CNT_W     = ctlr_pkg::CNT_W;

	typedef enum logic [2:0] {
		ST_IDLE  = 3'b001,
		ST_SCAN  = 3'b010,
		ST_WRITE = 3'b100
	} state_t;

	typedef logic [NUM_WAYS-1:0][TAG_W-1:0]    tag_row_t;
	typedef logic [NUM_WAYS-1:0][AGE_BITS-1:0] age_row_t;

	function automatic logic [AGE_BITS-1:0] age_inc(input logic [AGE_BITS-1:0] a);
		return (a == '1) ? a : a + 1'b1;
	endfunction

	// ------------------------------------------------------------------
	// Configuration registers
	// ------------------------------------------------------------------
	logic [ctlr_pkg::OFFSET_W-1:0] blk_ofs_w_q;
	logic [ctlr_pkg::INDEX_W-1:0]  set_sel_w_q;
	logic [ctlr_pkg::WAYS_W-1:0]   ways_in_use_q;
	logic                          replace_policy_q;
	logic                          cfg_wr;
	logic [ctlr_pkg::REG_IDX_W-1:0] cfg_idx;

	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite && pready;
	assign cfg_idx = paddr[ctlr_pkg::PADDR_W-1:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			blk_ofs_w_q      <= ctlr_pkg::BLK_OFS_W_RST;
			set_sel_w_q      <= ctlr_pkg::SET_SEL_W_RST;
			ways_in_use_q    <= ctlr_pkg::WAYS_IN_USE_RST;
			replace_policy_q <= ctlr_pkg::REPLACE_POLICY_RST;
		end else if (cfg_wr) begin
			case (cfg_idx)
				ctlr_pkg::REG_BLK_OFS_W: begin
					blk_ofs_w_q <= pwdata[ctlr_pkg::OFFSET_W-1:0];
				end
				ctlr_pkg::REG_SET_SEL_W: begin
					set_sel_w_q <= pwdata[ctlr_pkg::INDEX_W-1:0];
				end
				ctlr_pkg::REG_WAYS_IN_USE: begin
					ways_in_use_q <= pwdata[ctlr_pkg::WAYS_W-1:0];
				end
				ctlr_pkg::REG_REPLACE_POLICY: begin
					replace_policy_q <= pwdata[0];
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		case (cfg_idx)
			ctlr_pkg::REG_BLK_OFS_W:      prdata = ctlr_pkg::PDATA_W'(blk_ofs_w_q);
			ctlr_pkg::REG_SET_SEL_W:      prdata = ctlr_pkg::PDATA_W'(set_sel_w_q);
			ctlr_pkg::REG_WAYS_IN_USE:    prdata = ctlr_pkg::PDATA_W'(ways_in_use_q);
			ctlr_pkg::REG_REPLACE_POLICY: prdata = ctlr_pkg::PDATA_W'(replace_policy_q);
			default:                      prdata = '0;
		endcase
	end

	// Last way searched: zero ways counts as one, large counts clamp.
	logic [CMP_W-1:0] ways_cfg_ext;
	logic [WAY_W-1:0] last_way;

	assign ways_cfg_ext = CMP_W'(ways_in_use_q);

	always_comb begin
		if (ways_in_use_q == '0) begin
			last_way = '0;
		end else if (ways_cfg_ext >= CMP_W'(NUM_WAYS)) begin
			last_way = WAY_W'(NUM_WAYS - 1);
		end else begin
			last_way = WAY_W'(ways_in_use_q - 1'b1);
		end
	end

	// ------------------------------------------------------------------
	// Address split
	// ------------------------------------------------------------------
	// Index field wraps onto the store through a constant table.
	logic [SET_W-1:0] wrap_tab [IDX_RANGE];

	for (genvar gi = 0; gi < IDX_RANGE; gi++) begin : g_wrap
		assign wrap_tab[gi] = SET_W'(gi % NUM_SETS);
	end

	logic [ctlr_pkg::ADDR_W-1:0]    addr_shr;
	logic [ctlr_pkg::IDX_FIELD_W:0] idx_one;
	logic [ctlr_pkg::IDX_FIELD_W-1:0] idx_mask;
	logic [ctlr_pkg::IDX_FIELD_W-1:0] idx_raw;
	logic [SET_W-1:0]               set_in;
	logic [ctlr_pkg::SHAMT_W-1:0]   tag_shamt;
	logic [TAG_W-1:0]               tag_in;

	assign addr_shr  = req.payload.address >> blk_ofs_w_q;
	assign idx_one   = (ctlr_pkg::IDX_FIELD_W + 1)'(1) << set_sel_w_q;
	assign idx_mask  = ctlr_pkg::IDX_FIELD_W'(idx_one - 1'b1);
	assign idx_raw   = addr_shr[ctlr_pkg::IDX_FIELD_W-1:0] & idx_mask;
	assign set_in    = wrap_tab[idx_raw];
	assign tag_shamt = ctlr_pkg::SHAMT_W'(blk_ofs_w_q) + ctlr_pkg::SHAMT_W'(set_sel_w_q);
	assign tag_in    = TAG_W'(req.payload.address >> tag_shamt);

	// ------------------------------------------------------------------
	// Sequencer
	// ------------------------------------------------------------------
	state_t state_q;
	logic   in_acc;
	logic   out_load;
	logic   out_valid_q;

	assign req.ready = (state_q == ST_IDLE);
	assign in_acc    = req.valid && req.ready;
	assign out_load  = (state_q == ST_WRITE) && (!out_valid_q || rsp.ready);

	// ------------------------------------------------------------------
	// Storage: tag and age rows in memories, valid bits in flops
	// ------------------------------------------------------------------
	tag_row_t tag_mem  [NUM_SETS];
	age_row_t use_mem  [NUM_SETS];
	age_row_t fill_mem [NUM_SETS];
	logic [NUM_WAYS-1:0] valid_q [NUM_SETS];

	tag_row_t tag_row_q, tag_row_new;
	age_row_t use_row_q, use_row_new;
	age_row_t fill_row_q, fill_row_new;
	logic [NUM_WAYS-1:0] vrow_q;

	logic             mode_q;
	logic [TAG_W-1:0] tag_q;
	logic [SET_W-1:0] set_q;
	logic             mem_we;

	assign mem_we = out_load && (mode_q == ctlr_pkg::MODE_LOOKUP);

	always_ff @(posedge clk) begin
		if (in_acc) begin
			tag_row_q  <= tag_mem[set_in];
			use_row_q  <= use_mem[set_in];
			fill_row_q <= fill_mem[set_in];
		end
		if (mem_we) begin
			tag_mem[set_q]  <= tag_row_new;
			use_mem[set_q]  <= use_row_new;
			fill_mem[set_q] <= fill_row_new;
		end
	end

	// ------------------------------------------------------------------
	// Shared comparator: one way per scan cycle
	// ------------------------------------------------------------------
	logic [WAY_W-1:0]    way_q;
	logic                found_q;
	logic [WAY_W-1:0]    hit_way_q;
	logic                inv_found_q;
	logic [WAY_W-1:0]    inv_way_q;
	logic [AGE_BITS-1:0] best_age_q;
	logic [WAY_W-1:0]    best_way_q;

	logic                cur_valid;
	logic                tag_eq;
	logic [AGE_BITS-1:0] cur_age;
	logic                age_gt;

	assign cur_valid = vrow_q[way_q];
	assign tag_eq    = (tag_row_q[way_q] == tag_q);
	assign cur_age   = (replace_policy_q == ctlr_pkg::POLICY_FIFO) ? fill_row_q[way_q]
	                                                               : use_row_q[way_q];
	assign age_gt    = (cur_age > best_age_q);

	always_ff @(posedge clk) begin
		if (in_acc) begin
			mode_q      <= req.payload.mode;
			tag_q       <= tag_in;
			set_q       <= set_in;
			vrow_q      <= valid_q[set_in];
			found_q     <= 1'b0;
			inv_found_q <= 1'b0;
			hit_way_q   <= '0;
			inv_way_q   <= '0;
			best_way_q  <= '0;
			best_age_q  <= '0;
		end else if (state_q == ST_SCAN) begin
			// first valid match wins
			if (!found_q && cur_valid && tag_eq) begin
				found_q   <= 1'b1;
				hit_way_q <= way_q;
			end
			// lowest invalid way
			if (!inv_found_q && !cur_valid) begin
				inv_found_q <= 1'b1;
				inv_way_q   <= way_q;
			end
			// oldest way, ties keep the lower one
			if ((way_q == '0) || age_gt) begin
				best_age_q <= cur_age;
				best_way_q <= way_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			way_q   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						state_q <= ST_SCAN;
						way_q   <= '0;
					end
				end
				ST_SCAN: begin
					if (way_q == last_way) begin
						state_q <= ST_WRITE;
					end else begin
						way_q <= way_q + 1'b1;
					end
				end
				ST_WRITE: begin
					// hold until the response register is free
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// ------------------------------------------------------------------
	// Write-back cycle
	// ------------------------------------------------------------------
	logic [WAY_W-1:0] victim_way;
	logic [WAY_W-1:0] sel_way;
	logic             evict;
	logic [31:0]      sel_way_ext;

	always_comb begin
		if (inv_found_q) begin
			victim_way = inv_way_q;
		end else begin
			victim_way = best_way_q;
		end
		if (found_q) begin
			sel_way = hit_way_q;
		end else if (mode_q == ctlr_pkg::MODE_LOOKUP) begin
			sel_way = victim_way;
		end else begin
			sel_way = '0;
		end
		evict = (mode_q == ctlr_pkg::MODE_LOOKUP) && !found_q && !inv_found_q;
	end

	assign sel_way_ext = 32'(sel_way);

	// New row contents: age the other ways in use and zero the touched way; fill ages move only on a fill.
	always_comb begin
		tag_row_new  = tag_row_q;
		use_row_new  = use_row_q;
		fill_row_new = fill_row_q;
		for (int w = 0; w < NUM_WAYS; w++) begin
			if (WAY_W'(w) <= last_way) begin
				if (found_q) begin
					if (WAY_W'(w) == hit_way_q) begin
						use_row_new[w] = '0;
					end else begin
						use_row_new[w] = age_inc(use_row_q[w]);
					end
				end else if (WAY_W'(w) == victim_way) begin
					tag_row_new[w]  = tag_q;
					use_row_new[w]  = '0;
					fill_row_new[w] = '0;
				end else begin
					use_row_new[w]  = age_inc(use_row_q[w]);
					fill_row_new[w] = age_inc(fill_row_q[w]);
				end
			end
		end
	end

	// Valid bits and totals
	logic [CNT_W-1:0] hits_q;
	logic [CNT_W-1:0] misses_q;
	logic [CNT_W-1:0] invals_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int s = 0; s < NUM_SETS; s++) begin
				valid_q[s] <= '0;
			end
			hits_q   <= '0;
			misses_q <= '0;
			invals_q <= '0;
		end else if (out_load) begin
			if (mode_q == ctlr_pkg::MODE_INVALIDATE) begin
				if (found_q) begin
					valid_q[set_q][hit_way_q] <= 1'b0;
				end
				if (invals_q != '1) begin
					invals_q <= invals_q + 1'b1;
				end
			end else if (found_q) begin
				if (hits_q != '1) begin
					hits_q <= hits_q + 1'b1;
				end
			end else begin
				valid_q[set_q][victim_way] <= 1'b1;
				if (misses_q != '1) begin
					misses_q <= misses_q + 1'b1;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Response register
	// ------------------------------------------------------------------
	logic                           out_hit_q;
	logic [ctlr_pkg::WAY_OUT_W-1:0] out_way_q;
	logic                           out_evicted_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_hit_q     <= found_q;
			out_way_q     <= sel_way_ext[ctlr_pkg::WAY_OUT_W-1:0];
			out_evicted_q <= evict;
		end
	end

	// Totals only move on a response load, so they match the held word.
	assign rsp.valid                    = out_valid_q;
	assign rsp.payload.hit              = out_hit_q;
	assign rsp.payload.way              = out_way_q;
	assign rsp.payload.evicted          = out_evicted_q;
	assign rsp.payload.hit_total        = hits_q;
	assign rsp.payload.miss_total       = misses_q;
	assign rsp.payload.invalidate_total = invals_q;

	// ------------------------------------------------------------------
	// Checks
	// ------------------------------------------------------------------
	`CTLR_ASSERT_IMP(a_load_from_write, $rose(out_valid_q), $past(state_q) == ST_WRITE)
	`CTLR_ASSERT_IMP(a_hit_not_evicted, out_valid_q, !(out_hit_q && out_evicted_q))
	`CTLR_ASSERT_NEXT(a_totals_hold, !out_load, $stable(hits_q) && $stable(misses_q) && $stable(invals_q))
	`CTLR_ASSERT_NEXT(a_accept_starts_scan, in_acc, (state_q == ST_SCAN) && (way_q == '0))

endmodule
